FILE: sv/tmhq_pkg.sv
// ----------------------------------------------------------------------------
// tmhq_pkg
// Shared types, codes and the ordering function of the triage min-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tmhq_pkg;

    // Node and level fields are sized for the largest supported capacity (4096)
    localparam int NODE_MAX_W = 14;
    localparam int LVL_MAX_W  = 4;
    localparam int OCC_W      = 7;

    // Operation codes
    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // One stored heap entry
    typedef struct packed {
        logic [15:0] arrival;
        logic [7:0]  prio;
        logic [15:0] id;
    } t_entry;

    // Input item
    typedef struct packed {
        logic        func;
        logic [15:0] arrival;
        logic [7:0]  priority_req;
        logic [15:0] patient_id;
    } t_in;

    // Result item
    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      out_arrival;
        logic [7:0]       out_priority;
        logic [15:0]      out_id;
        logic [OCC_W-1:0] occupancy;
    } t_out;

    // Read request to the level cells (root reads level 0 alongside)
    typedef struct packed {
        logic                  en;
        logic                  root;
        logic [LVL_MAX_W-1:0]  lvl;
        logic [NODE_MAX_W-1:0] node;
    } t_rd_port;

    // Write request to one level cell
    typedef struct packed {
        logic                  en;
        logic [LVL_MAX_W-1:0]  lvl;
        logic [NODE_MAX_W-1:0] node;
        t_entry                data;
    } t_wr_port;

    // Entry a goes before entry b: lower priority, then earlier arrival
    function automatic logic better(input t_entry a, input t_entry b);
        return (a.prio < b.prio) || ((a.prio == b.prio) && (a.arrival < b.arrival));
    endfunction

endpackage

`default_nettype wire

FILE: sv/tmhq_level.sv
// ----------------------------------------------------------------------------
// tmhq_level
// One heap level: holds all nodes of that level as sibling pairs, one row per
// parent, with a registered read of a whole row.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhq_level #(
    parameter int LEVEL    = 0,
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  tmhq_pkg::t_rd_port  i_rd,
    input  tmhq_pkg::t_wr_port  i_wr0,
    input  tmhq_pkg::t_wr_port  i_wr1,
    output tmhq_pkg::t_entry    o_left,
    output tmhq_pkg::t_entry    o_right,
    output tmhq_pkg::t_entry    o_pick
);

    // Nodes of this level run from FIRST to LAST (1-based heap numbering)
    localparam int FIRST     = 2 ** LEVEL;
    localparam int LAST_FULL = 2 ** (LEVEL + 1) - 1;
    localparam int LAST      = (CAPACITY < LAST_FULL) ? CAPACITY : LAST_FULL;
    localparam int ROWS      = ((LAST - FIRST) >> 1) + 1;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [tmhq_pkg::LVL_MAX_W-1:0] MY_LVL = tmhq_pkg::LVL_MAX_W'(LEVEL);

    tmhq_pkg::t_entry   r_mem_a [ROWS];
    tmhq_pkg::t_entry   r_mem_b [ROWS];
    tmhq_pkg::t_entry   r_left;
    tmhq_pkg::t_entry   r_right;
    logic               r_side;

    tmhq_pkg::t_wr_port wr;
    logic               wr_hit;
    logic               rd_hit;
    logic [ROW_W-1:0]   rd_row;
    logic [ROW_W-1:0]   wr_row;
    logic               rd_side;
    logic               wr_side;

    // Pick the write port aimed at this level
    assign wr     = (i_wr0.en && (i_wr0.lvl == MY_LVL)) ? i_wr0 : i_wr1;
    assign wr_hit = wr.en && (wr.lvl == MY_LVL);
    assign rd_hit = (i_rd.en && (i_rd.lvl == MY_LVL)) || ((LEVEL == 0) && i_rd.root);

    // Row is the parent's place in the level above, side is the low node bit
    generate
        if (ROWS > 1) begin : g_rows
            assign rd_row = i_rd.node[ROW_W:1];
            assign wr_row = wr.node[ROW_W:1];
        end else begin : g_one_row
            assign rd_row = '0;
            assign wr_row = '0;
        end
        if (LEVEL == 0) begin : g_root
            assign rd_side = 1'b0;
            assign wr_side = 1'b0;
        end else begin : g_pairs
            assign rd_side = i_rd.node[0];
            assign wr_side = wr.node[0];
        end
    endgenerate

    // Write one side of a row
    always_ff @(posedge i_clk) begin
        if (wr_hit && !wr_side) begin
            r_mem_a[wr_row] <= wr.data;
        end
        if (wr_hit && wr_side) begin
            r_mem_b[wr_row] <= wr.data;
        end
    end

    // Read a whole row and remember which side was addressed
    always_ff @(posedge i_clk) begin
        if (rd_hit) begin
            r_left  <= r_mem_a[rd_row];
            r_right <= r_mem_b[rd_row];
            r_side  <= rd_side;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_pick  = r_side ? r_right : r_left;

endmodule

`default_nettype wire

FILE: sv/tmhq_ctrl.sv
// ----------------------------------------------------------------------------
// tmhq_ctrl
// Sift sequencer: walks one level per cycle up or down the row of level
// cells, carrying the moving entry in a register, and issues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhq_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  tmhq_pkg::t_in        i_item,
    input  tmhq_pkg::t_entry     i_pick  [$clog2(CAPACITY + 1)],
    input  tmhq_pkg::t_entry     i_left  [$clog2(CAPACITY + 1)],
    input  tmhq_pkg::t_entry     i_right [$clog2(CAPACITY + 1)],
    output tmhq_pkg::t_rd_port   o_rd,
    output tmhq_pkg::t_wr_port   o_wr0,
    output tmhq_pkg::t_wr_port   o_wr1,
    output logic                 o_busy,
    output logic                 o_strobe,
    output tmhq_pkg::t_out       o_result
);

    localparam int LVLS   = $clog2(CAPACITY + 1);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int NODE_W = CNT_W + 1;
    localparam int LW     = tmhq_pkg::LVL_MAX_W;
    localparam int NW     = tmhq_pkg::NODE_MAX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXT  = 2'd1;
    localparam logic [1:0] S_DOWN = 2'd2;
    localparam logic [1:0] S_UP   = 2'd3;

    localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
    localparam logic [LW-1:0]     LVL_ONE   = LW'(1);
    localparam logic [LW-1:0]     LVL_TWO   = LW'(2);

    // Level of a node: position of its leading one
    function automatic logic [LW-1:0] lvl_of(input logic [NODE_W-1:0] node);
        logic [LW-1:0] l;
        l = '0;
        for (int b = 0; b < NODE_W; b++) begin
            if (node[b]) begin
                l = LW'(b);
            end
        end
        return l;
    endfunction

    logic [1:0]         r_state,  n_state;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [NODE_W-1:0]  r_node,   n_node;
    logic [LW-1:0]      r_lvl,    n_lvl;
    logic [LW-1:0]      r_rd_lvl, n_rd_lvl;
    tmhq_pkg::t_entry   r_cur,    n_cur;
    tmhq_pkg::t_entry   r_res,    n_res;
    logic               r_strobe, n_strobe;
    tmhq_pkg::t_out     r_out,    n_out;

    tmhq_pkg::t_entry   rd_pick;
    tmhq_pkg::t_entry   rd_left;
    tmhq_pkg::t_entry   rd_right;
    tmhq_pkg::t_entry   new_entry;
    tmhq_pkg::t_entry   out_e;
    tmhq_pkg::t_entry   best_e;
    logic [1:0]         fin_status;
    logic               fin;
    logic               go_l;
    logic               go_r;
    logic [NODE_W-1:0]  node_ins;
    logic [NODE_W-1:0]  node_last;
    logic [NODE_W-1:0]  kid_l;
    logic [NODE_W-1:0]  kid_r;
    logic [NODE_W-1:0]  cnode;
    logic [NODE_W-1:0]  cnode_kid;
    logic [NODE_W-1:0]  pnode;
    logic [NODE_W-1:0]  count_ext;
    logic [LW-1:0]      lvl_ins;
    logic [LW-1:0]      lvl_last;

    // Select the row read back from the level addressed last cycle
    always_comb begin
        rd_pick  = '0;
        rd_left  = '0;
        rd_right = '0;
        for (int k = 0; k < LVLS; k++) begin
            if (r_rd_lvl == LW'(k)) begin
                rd_pick  = i_pick[k];
                rd_left  = i_left[k];
                rd_right = i_right[k];
            end
        end
    end

    // Node arithmetic for the current step
    assign count_ext = NODE_W'(r_count);
    assign node_ins  = count_ext + ROOT_NODE;
    assign node_last = count_ext;
    assign lvl_ins   = lvl_of(node_ins);
    assign lvl_last  = lvl_of(node_last);
    assign kid_l     = {r_node[NODE_W-2:0], 1'b0};
    assign kid_r     = {r_node[NODE_W-2:0], 1'b1};
    assign pnode     = r_node >> 1;

    assign new_entry.arrival = i_item.arrival;
    assign new_entry.prio    = i_item.priority_req;
    assign new_entry.id      = i_item.patient_id;

    // Compare the moving entry with its children
    always_comb begin
        go_l   = tmhq_pkg::better(rd_left, r_cur);
        best_e = go_l ? rd_left : r_cur;
        go_r   = (kid_r <= count_ext) && tmhq_pkg::better(rd_right, best_e);
        cnode  = go_r ? kid_r : kid_l;
    end
    assign cnode_kid = {cnode[NODE_W-2:0], 1'b0};

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_node     = r_node;
        n_lvl      = r_lvl;
        n_rd_lvl   = r_rd_lvl;
        n_cur      = r_cur;
        n_res      = r_res;
        o_rd       = '0;
        o_wr0      = '0;
        o_wr1      = '0;
        fin        = 1'b0;
        fin_status = tmhq_pkg::STATUS_OK;
        out_e      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cur = new_entry;
                    if (i_item.func == tmhq_pkg::FUNC_INSERT) begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            // Drop the item and report full
                            fin        = 1'b1;
                            fin_status = tmhq_pkg::STATUS_FULL;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_node  = node_ins;
                            n_lvl   = lvl_ins;
                            if (node_ins == ROOT_NODE) begin
                                o_wr0.en   = 1'b1;
                                o_wr0.lvl  = '0;
                                o_wr0.node = NW'(ROOT_NODE);
                                o_wr0.data = new_entry;
                                fin        = 1'b1;
                            end else begin
                                // Fetch the parent for the first sift-up step
                                o_rd.en   = 1'b1;
                                o_rd.lvl  = lvl_ins - LVL_ONE;
                                o_rd.node = NW'(node_ins >> 1);
                                n_rd_lvl  = lvl_ins - LVL_ONE;
                                n_state   = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            fin        = 1'b1;
                            fin_status = tmhq_pkg::STATUS_EMPTY;
                        end else begin
                            // Fetch root and last entry together
                            o_rd.en   = 1'b1;
                            o_rd.root = 1'b1;
                            o_rd.lvl  = lvl_last;
                            o_rd.node = NW'(node_last);
                            n_rd_lvl  = lvl_last;
                            n_count   = r_count - CNT_W'(1);
                            n_state   = S_EXT;
                        end
                    end
                end
            end

            S_EXT: begin
                // Hold the root for the result, move the last entry to the top
                n_res  = i_pick[0];
                out_e  = i_pick[0];
                n_cur  = rd_pick;
                n_node = ROOT_NODE;
                n_lvl  = '0;
                if (r_count == '0) begin
                    fin = 1'b1;
                end else if (r_count == CNT_W'(1)) begin
                    o_wr0.en   = 1'b1;
                    o_wr0.lvl  = '0;
                    o_wr0.node = NW'(ROOT_NODE);
                    o_wr0.data = rd_pick;
                    fin        = 1'b1;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.lvl  = LVL_ONE;
                    o_rd.node = NW'(NODE_W'(2));
                    n_rd_lvl  = LVL_ONE;
                    n_state   = S_DOWN;
                end
            end

            S_DOWN: begin
                out_e = r_res;
                if (!go_l && !go_r) begin
                    // Settle the moving entry here
                    o_wr0.en   = 1'b1;
                    o_wr0.lvl  = r_lvl;
                    o_wr0.node = NW'(r_node);
                    o_wr0.data = r_cur;
                    fin        = 1'b1;
                end else begin
                    // Lift the better child and descend
                    o_wr0.en   = 1'b1;
                    o_wr0.lvl  = r_lvl;
                    o_wr0.node = NW'(r_node);
                    o_wr0.data = go_r ? rd_right : rd_left;
                    n_node     = cnode;
                    n_lvl      = r_lvl + LVL_ONE;
                    if (cnode_kid <= count_ext) begin
                        o_rd.en   = 1'b1;
                        o_rd.lvl  = r_lvl + LVL_TWO;
                        o_rd.node = NW'(cnode_kid);
                        n_rd_lvl  = r_lvl + LVL_TWO;
                    end else begin
                        o_wr1.en   = 1'b1;
                        o_wr1.lvl  = r_lvl + LVL_ONE;
                        o_wr1.node = NW'(cnode);
                        o_wr1.data = r_cur;
                        fin        = 1'b1;
                    end
                end
            end

            S_UP: begin
                if (tmhq_pkg::better(r_cur, rd_pick)) begin
                    // Drop the parent one level and climb
                    o_wr0.en   = 1'b1;
                    o_wr0.lvl  = r_lvl;
                    o_wr0.node = NW'(r_node);
                    o_wr0.data = rd_pick;
                    n_node     = pnode;
                    n_lvl      = r_lvl - LVL_ONE;
                    if (pnode == ROOT_NODE) begin
                        o_wr1.en   = 1'b1;
                        o_wr1.lvl  = '0;
                        o_wr1.node = NW'(ROOT_NODE);
                        o_wr1.data = r_cur;
                        fin        = 1'b1;
                    end else begin
                        o_rd.en   = 1'b1;
                        o_rd.lvl  = r_lvl - LVL_TWO;
                        o_rd.node = NW'(pnode >> 1);
                        n_rd_lvl  = r_lvl - LVL_TWO;
                    end
                end else begin
                    o_wr0.en   = 1'b1;
                    o_wr0.lvl  = r_lvl;
                    o_wr0.node = NW'(r_node);
                    o_wr0.data = r_cur;
                    fin        = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Build the result item
        n_strobe           = fin;
        n_out.status       = fin_status;
        n_out.out_arrival  = out_e.arrival;
        n_out.out_priority = out_e.prio;
        n_out.out_id       = out_e.id;
        n_out.occupancy    = tmhq_pkg::OCC_W'(n_count);
        if (fin) begin
            n_state = S_IDLE;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_lvl    <= n_lvl;
        r_rd_lvl <= n_rd_lvl;
        r_cur    <= n_cur;
        r_res    <= n_res;
        if (n_strobe) begin
            r_out <= n_out;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

FILE: sv/triage_min_heap_queue.sv
// ----------------------------------------------------------------------------
// triage_min_heap_queue
// Bounded min-priority queue kept as a binary min-heap, one cell per level.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high while
// the heap is being repaired, and each item gives exactly one result, shown
// on o_result for a single cycle with o_strobe high. The receiver cannot
// stall, so it must take the result in that cycle. The heap is split into
// one storage cell per tree level, and the sequencer moves one level per
// cycle. An item that needs no sift (extract from an empty queue, insert
// into a full or an empty queue) is finished as it is taken and busy never
// rises. Any other insert fetches the parent, then compares with one parent
// per level; any other extract fetches the root and the last entry, moves
// the last entry to the top, then compares with one pair of children per
// level. The result is shown in the cycle after the one in which the
// sequencer finishes, the same cycle in which busy is low again, so the
// next item can be taken while the result is on the ports. Extracting from
// an empty queue reports empty; inserting into a full queue drops the item
// and reports full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module triage_min_heap_queue #(
    parameter int CAPACITY = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tmhq_pkg::t_in   i_item,
    output logic            o_strobe,
    output tmhq_pkg::t_out  o_result
);

    localparam int LVLS = $clog2(CAPACITY + 1);

    tmhq_pkg::t_rd_port rd;
    tmhq_pkg::t_wr_port wr0;
    tmhq_pkg::t_wr_port wr1;
    tmhq_pkg::t_entry   pick  [LVLS];
    tmhq_pkg::t_entry   left  [LVLS];
    tmhq_pkg::t_entry   right [LVLS];

    // Sift sequencer
    tmhq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_pick   (pick),
        .i_left   (left),
        .i_right  (right),
        .o_rd     (rd),
        .o_wr0    (wr0),
        .o_wr1    (wr1),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // One storage cell per heap level
    generate
        for (genvar k = 0; k < LVLS; k++) begin : g_level
            tmhq_level #(
                .LEVEL    (k),
                .CAPACITY (CAPACITY)
            ) u_level (
                .i_clk   (i_clk),
                .i_rd    (rd),
                .i_wr0   (wr0),
                .i_wr1   (wr1),
                .o_left  (left[k]),
                .o_right (right[k]),
                .o_pick  (pick[k])
            );
        end
    endgenerate

endmodule

`default_nettype wire

FILE: verif/triage_min_heap_queue_test.sv
// ----------------------------------------------------------------------------
// triage_min_heap_queue_test
// Self-checking bench for the triage min-heap queue. It sends insert and
// extract items through the start/busy handshake and keeps its own heap of
// entries to predict every result. It covers key extremes, ties, empty and
// full reports, and long random mixes with random sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module triage_min_heap_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    tmhq_pkg::t_in    i_item = '0;
    logic             o_strobe;
    tmhq_pkg::t_out   o_result;

    // Predicted heap contents and occupancy
    tmhq_pkg::t_entry heap_mem [HEAP_DEPTH];
    int     heap_count = 0;

    // Results still owed by the block, oldest first
    tmhq_pkg::t_out   pending_results [$];

    int     mismatch_count = 0;
    int     stall_cycles = 0;
    bit     gaps_enabled = 1'b1;
    int     n_items = 0;
    int     n_inserts = 0;
    int     n_extracts = 0;
    int     n_empty = 0;
    int     n_full = 0;
    int     peak_count = 0;

    triage_min_heap_queue #(
        .CAPACITY (HEAP_DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lower priority first, then earlier arrival
    function automatic logic served_first(input tmhq_pkg::t_entry a,
                                          input tmhq_pkg::t_entry b);
        if (a.prio != b.prio)
            return a.prio < b.prio;
        return a.arrival < b.arrival;
    endfunction

    function automatic void swap_entries(input int i, input int j);
        tmhq_pkg::t_entry held;
        held = heap_mem[i];
        heap_mem[i] = heap_mem[j];
        heap_mem[j] = held;
    endfunction

    // Apply one item to the predicted heap and return the result it gives
    function automatic tmhq_pkg::t_out heap_service(input tmhq_pkg::t_in item);
        tmhq_pkg::t_out res;
        int   pos;
        int   parent;
        int   child;
        int   best;
        res = '0;
        if (item.func == tmhq_pkg::FUNC_INSERT) begin
            if (heap_count >= HEAP_DEPTH) begin
                res.status = tmhq_pkg::STATUS_FULL;
            end else begin
                pos = heap_count;
                heap_mem[pos].arrival = item.arrival;
                heap_mem[pos].prio    = item.priority_req;
                heap_mem[pos].id      = item.patient_id;
                heap_count++;
                // sift the new entry up
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!served_first(heap_mem[pos], heap_mem[parent]))
                        break;
                    swap_entries(pos, parent);
                    pos = parent;
                end
            end
        end else begin
            if (heap_count == 0) begin
                res.status = tmhq_pkg::STATUS_EMPTY;
            end else begin
                res.out_arrival  = heap_mem[0].arrival;
                res.out_priority = heap_mem[0].prio;
                res.out_id       = heap_mem[0].id;
                heap_count--;
                heap_mem[0] = heap_mem[heap_count];
                // sift the moved last entry down
                pos = 0;
                while (pos < heap_count) begin
                    best  = pos;
                    child = 2 * pos + 1;
                    if (child < heap_count && served_first(heap_mem[child], heap_mem[best]))
                        best = child;
                    child = 2 * pos + 2;
                    if (child < heap_count && served_first(heap_mem[child], heap_mem[best]))
                        best = child;
                    if (best == pos)
                        break;
                    swap_entries(pos, best);
                    pos = best;
                end
            end
        end
        res.occupancy = tmhq_pkg::OCC_W'(heap_count);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    // Offer one item, hold it until taken, then idle now and then
    task automatic send_item(input tmhq_pkg::t_in item);
        tmhq_pkg::t_out res;
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy);
        res = heap_service(item);
        pending_results.push_back(res);
        n_items++;
        if (item.func == tmhq_pkg::FUNC_INSERT)
            n_inserts++;
        else
            n_extracts++;
        if (res.status == tmhq_pkg::STATUS_EMPTY)
            n_empty++;
        if (res.status == tmhq_pkg::STATUS_FULL)
            n_full++;
        if (heap_count > peak_count)
            peak_count = heap_count;
        if (gaps_enabled) begin
            while ($urandom_range(0, 99) < 29) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // Random item; narrow keys half the time so ties are common
    function automatic tmhq_pkg::t_in random_item(input logic func);
        tmhq_pkg::t_in item;
        item.func         = func;
        item.arrival      = $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
                                                 : 16'($urandom);
        item.priority_req = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom);
        item.patient_id   = 16'($urandom);
        return item;
    endfunction

    function automatic tmhq_pkg::t_in entry_item(input int prio, input int arrival,
                                                 input int id);
        tmhq_pkg::t_in item;
        item.func         = tmhq_pkg::FUNC_INSERT;
        item.arrival      = 16'(arrival);
        item.priority_req = 8'(prio);
        item.patient_id   = 16'(id);
        return item;
    endfunction

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        tmhq_pkg::t_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no item outstanding", $time);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status != want.status)
                    report_mismatch("status", int'(o_result.status),
                                    int'(want.status));
                if (o_result.out_arrival != want.out_arrival)
                    report_mismatch("out_arrival", int'(o_result.out_arrival),
                                    int'(want.out_arrival));
                if (o_result.out_priority != want.out_priority)
                    report_mismatch("out_priority", int'(o_result.out_priority),
                                    int'(want.out_priority));
                if (o_result.out_id != want.out_id)
                    report_mismatch("out_id", int'(o_result.out_id),
                                    int'(want.out_id));
                if (o_result.occupancy != want.occupancy)
                    report_mismatch("occupancy", int'(o_result.occupancy),
                                    int'(want.occupancy));
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no progress, %0d results outstanding", $time,
                         pending_results.size());
                $display("triage_min_heap_queue_test: FAIL");
                $finish;
            end
        end
    end

    // Extract from the queue right after reset
    task automatic test_empty_extract();
        send_item(random_item(tmhq_pkg::FUNC_EXTRACT));
        send_item(random_item(tmhq_pkg::FUNC_EXTRACT));
    endtask

    // Key extremes, equal priorities and fully equal keys, then drain
    task automatic test_key_order();
        send_item(entry_item(255, 65535, 65535));
        send_item(entry_item(0, 65535, 1));
        send_item(entry_item(0, 0, 0));
        send_item(entry_item(0, 0, 2));
        send_item(entry_item(128, 5, 21845));
        send_item(entry_item(128, 4, 43690));
        send_item(entry_item(128, 4, 3));
        send_item(entry_item(255, 0, 4));
        repeat (8) send_item(random_item(tmhq_pkg::FUNC_EXTRACT));
        send_item(random_item(tmhq_pkg::FUNC_EXTRACT));
    endtask

    // Fill to capacity, push past it, then drain past empty
    task automatic test_full_and_drain();
        while (heap_count < HEAP_DEPTH)
            send_item(random_item(tmhq_pkg::FUNC_INSERT));
        repeat (3) send_item(random_item(tmhq_pkg::FUNC_INSERT));
        while (heap_count > 0)
            send_item(random_item(tmhq_pkg::FUNC_EXTRACT));
        repeat (2) send_item(random_item(tmhq_pkg::FUNC_EXTRACT));
    endtask

    // Random mix; the insert share shifts so occupancy sweeps its range
    task automatic test_random_mix(input int count);
        int insert_pct;
        insert_pct = 50;
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0)
                insert_pct = ($urandom_range(0, 2) == 0) ? 30
                           : ($urandom_range(0, 1) ? 50 : 75);
            // one long run without sender gaps
            gaps_enabled = !(k >= 500 && k < 850);
            send_item(random_item($urandom_range(0, 99) < insert_pct
                                  ? tmhq_pkg::FUNC_INSERT
                                  : tmhq_pkg::FUNC_EXTRACT));
        end
        gaps_enabled = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_extract();
        test_key_order();
        test_full_and_drain();
        test_random_mix(1650);
        test_full_and_drain();

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d inserts, %0d extracts, peak occupancy %0d",
                 n_items, n_inserts, n_extracts, peak_count);
        $display("Empty reports %0d, full reports %0d, mismatches %0d",
                 n_empty, n_full, mismatch_count);
        if (mismatch_count == 0)
            $display("triage_min_heap_queue_test: PASS");
        else
            $display("triage_min_heap_queue_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/tmhq_pkg.sv
sv/tmhq_level.sv
sv/tmhq_ctrl.sv
sv/triage_min_heap_queue.sv
verif/triage_min_heap_queue_test.sv
